// File: hw/rtl/scfp_pkg.sv
package scfp_pkg;

   // Start-of-frame marker
   localparam logic [7:0] START_BYTE = 8'h3a;

   // Record kinds
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_END     = 1'b1;

   // Parser state; codes follow the byte position inside a frame
   typedef enum logic [3:0] {
      ST_HUNT  = 4'd0,
      ST_ADDR0 = 4'd1,
      ST_ADDR1 = 4'd2,
      ST_FUNC0 = 4'd3,
      ST_FUNC1 = 4'd4,
      ST_LEN0  = 4'd5,
      ST_LEN1  = 4'd6,
      ST_DATA  = 4'd7,
      ST_CHK1  = 4'd8
   } parse_state_type;

   // One result record
   typedef struct packed {
      logic        record_kind;
      logic [15:0] frame_address;
      logic [15:0] frame_function;
      logic [15:0] frame_length;
      logic [15:0] byte_index;
      logic [7:0]  payload_byte;
      logic        checksum_ok;
      logic        last;
   } rsp_rec_type;

   // Parser step outcome
   typedef struct packed {
      logic        valid;
      rsp_rec_type rec;
   } parse_result_type;

endpackage

// File: hw/rtl/scfp_req_if.sv
interface scfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: hw/rtl/scfp_rsp_if.sv
interface scfp_rsp_if;
   logic        valid;
   logic        ready;
   logic        record_kind;
   logic [15:0] frame_address;
   logic [15:0] frame_function;
   logic [15:0] frame_length;
   logic [15:0] byte_index;
   logic [7:0]  payload_byte;
   logic        checksum_ok;
   logic        last;

   modport source (
      output valid, output record_kind, output frame_address, output frame_function,
      output frame_length, output byte_index, output payload_byte, output checksum_ok,
      output last, input ready
   );
   modport sink (
      input valid, input record_kind, input frame_address, input frame_function,
      input frame_length, input byte_index, input payload_byte, input checksum_ok,
      input last, output ready
   );
endinterface

// File: hw/rtl/scfp_parser.sv
module scfp_parser (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  logic [7:0]                rx_byte,
   output scfp_pkg::parse_result_type result
);
   import scfp_pkg::*;

   parse_state_type state_ff, state_in;
   logic [15:0]     addr_ff, addr_in;
   logic [15:0]     func_ff, func_in;
   logic [15:0]     len_ff, len_in;
   logic [15:0]     remain_ff, remain_in;
   logic [15:0]     sum_ff, sum_in;
   logic [7:0]      chk_low_ff, chk_low_in;
   logic [15:0]     len_full;
   logic [15:0]     received;

   assign len_full = {rx_byte, len_ff[7:0]};
   assign received = {rx_byte, chk_low_ff};

   // Next state and field capture
   always_comb begin
      state_in   = state_ff;
      addr_in    = addr_ff;
      func_in    = func_ff;
      len_in     = len_ff;
      remain_in  = remain_ff;
      sum_in     = sum_ff;
      chk_low_in = chk_low_ff;
      case (state_ff)
         ST_HUNT: begin
            if (rx_byte == START_BYTE) state_in = ST_ADDR0;
         end
         ST_ADDR0: begin
            addr_in  = {8'h00, rx_byte};
            state_in = ST_ADDR1;
         end
         ST_ADDR1: begin
            addr_in  = {rx_byte, addr_ff[7:0]};
            state_in = ST_FUNC0;
         end
         ST_FUNC0: begin
            func_in  = {8'h00, rx_byte};
            state_in = ST_FUNC1;
         end
         ST_FUNC1: begin
            func_in  = {rx_byte, func_ff[7:0]};
            state_in = ST_LEN0;
         end
         ST_LEN0: begin
            len_in   = {8'h00, rx_byte};
            state_in = ST_LEN1;
         end
         ST_LEN1: begin
            len_in    = len_full;
            remain_in = len_full;
            sum_in    = addr_ff + func_ff + len_full;
            state_in  = ST_DATA;
         end
         ST_DATA: begin
            // Zero remaining: this byte is the checksum's low byte
            if (remain_ff == 16'd0) begin
               chk_low_in = rx_byte;
               state_in   = ST_CHK1;
            end else begin
               sum_in    = sum_ff + {8'h00, rx_byte};
               remain_in = remain_ff - 16'd1;
            end
         end
         ST_CHK1: begin
            state_in = ST_HUNT;
         end
         default: begin
            state_in = ST_HUNT;
         end
      endcase
   end

   // Result record for the current byte
   always_comb begin
      result                    = '0;
      result.rec.frame_address  = addr_ff;
      result.rec.frame_function = func_ff;
      result.rec.frame_length   = len_ff;
      case (state_ff)
         ST_DATA: begin
            if (remain_ff != 16'd0) begin
               result.valid            = 1'b1;
               result.rec.record_kind  = KIND_PAYLOAD;
               result.rec.byte_index   = len_ff - remain_ff;
               result.rec.payload_byte = rx_byte;
            end
         end
         ST_CHK1: begin
            result.valid           = 1'b1;
            result.rec.record_kind = KIND_END;
            result.rec.last        = 1'b1;
            result.rec.checksum_ok = (received == sum_ff);
         end
         default: begin
            result.valid = 1'b0;
         end
      endcase
   end

   // Advance parser state on each processed byte
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_HUNT;
         addr_ff    <= '0;
         func_ff    <= '0;
         len_ff     <= '0;
         remain_ff  <= '0;
         sum_ff     <= '0;
         chk_low_ff <= '0;
      end else if (step) begin
         state_ff   <= state_in;
         addr_ff    <= addr_in;
         func_ff    <= func_in;
         len_ff     <= len_in;
         remain_ff  <= remain_in;
         sum_ff     <= sum_in;
         chk_low_ff <= chk_low_in;
      end
   end

endmodule

// File: hw/rtl/sum_checked_frame_parser_core.sv
// Frame parser with additive 16-bit checksum.
// req_ch carries one received link byte per transfer (valid/ready). The block
// hunts for the start byte 0x3a, then reads little-endian address, function
// and length words, the payload and a little-endian checksum word.
// rsp_ch gives one payload record per payload byte (index, byte and header
// fields) and one end record after the checksum, flagged last, with
// checksum_ok set when the sum of header words and payload bytes matches.
// Bytes outside a frame produce no transfer on rsp_ch.
// A byte taken on req_ch is held in the input register; the parser logic
// between it and the output register forms its result, offered on rsp_ch.
// Throughput: one byte per cycle unless rsp_ch stalls; the parser state
// update is the only loop.
// req_ch.ready stays high while the output register is empty or being
// drained; when rsp_ch stalls with a result held, both registers hold and
// req_ch.ready drops until the result is taken.
// Reset (synchronous, active high) empties both registers and returns the
// parser to hunting for the start byte with all header fields cleared.
module sum_checked_frame_parser_core (
   input logic       clock,
   input logic       reset,
   scfp_req_if.sink   req_ch,
   scfp_rsp_if.source rsp_ch
);
   import scfp_pkg::*;

   logic             advance;
   logic             in_valid_ff, in_valid_in;
   logic [7:0]       in_byte_ff, in_byte_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_rec_type      rsp_rec_ff, rsp_rec_in;
   parse_result_type result;

   // Move the pipe whenever the output register can take a new value
   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = advance;

   scfp_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (advance && in_valid_ff),
      .rx_byte (in_byte_ff),
      .result  (result)
   );

   // Next values of the input and output registers
   always_comb begin
      in_valid_in  = in_valid_ff;
      in_byte_in   = in_byte_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_rec_in   = rsp_rec_ff;
      if (advance) begin
         in_valid_in  = req_ch.valid;
         in_byte_in   = req_ch.rx_byte;
         rsp_valid_in = in_valid_ff && result.valid;
         rsp_rec_in   = result.rec;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      rsp_rec_ff <= rsp_rec_in;
   end

   // Drive the result channel
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.record_kind    = rsp_rec_ff.record_kind;
   assign rsp_ch.frame_address  = rsp_rec_ff.frame_address;
   assign rsp_ch.frame_function = rsp_rec_ff.frame_function;
   assign rsp_ch.frame_length   = rsp_rec_ff.frame_length;
   assign rsp_ch.byte_index     = rsp_rec_ff.byte_index;
   assign rsp_ch.payload_byte   = rsp_rec_ff.payload_byte;
   assign rsp_ch.checksum_ok    = rsp_rec_ff.checksum_ok;
   assign rsp_ch.last           = rsp_rec_ff.last;

`ifndef NO_ASSERTIONS
   a_held_byte_kept: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff))
      else $error("held input byte lost while stalled");

   a_reset_empties: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid_ff && !in_valid_ff)
      else $error("pipeline not empty after reset");

   a_last_on_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_rec_ff.last == rsp_rec_ff.record_kind)
      else $error("last flag disagrees with record kind");

   a_payload_no_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_rec_ff.record_kind == KIND_PAYLOAD |-> !rsp_rec_ff.checksum_ok)
      else $error("checksum_ok set on a payload record");

   a_end_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_rec_ff.record_kind == KIND_END
         |-> rsp_rec_ff.byte_index == 16'd0 && rsp_rec_ff.payload_byte == 8'd0)
      else $error("end record carries payload fields");
`endif

endmodule
